// ===== src/sdf_pkg.sv =====
// package for the snp packet deframer
// holds the phase, word-kind and status codes and the types shared by front, queue and back
// depends on nothing
`timescale 1ns / 1ps

package sdf_pkg;

	localparam int MAX_BATCH_WORDS_DEF = 15;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [7:0]  CH_S    = 8'h73;
	localparam logic [7:0]  CH_N    = 8'h6E;
	localparam logic [7:0]  CH_P    = 8'h70;
	localparam logic [15:0] HDR_SUM = 16'({8'h00, CH_S}) + 16'({8'h00, CH_N}) + 16'({8'h00, CH_P});
	localparam logic [2:0]  MIN_BUFFER_BYTES = 3'd7;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_TYPE = 3'd1,
		PH_ADDR = 3'd2,
		PH_DATA = 3'd3,
		PH_CKHI = 3'd4,
		PH_CKLO = 3'd5,
		PH_DONE = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		K_IGNORE = 3'd0,
		K_HDR    = 3'd1,
		K_TYPE   = 3'd2,
		K_ADDR   = 3'd3,
		K_DATA   = 3'd4,
		K_CKHI   = 3'd5,
		K_CKLO   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_NO_HEADER = 3'd2,
		ST_TRUNCATED = 3'd3,
		ST_MISMATCH  = 3'd4
	} status_t;

	// one classified word handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       eob;
		logic       eob_emit;
		status_t    eob_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== src/snp_packet_deframer.sv =====
// snp packet deframer top level: front classifier, command queue, back datapath
// an accepted word is stored in a queue entry, and its result, if it has one, is then registered in the result register
// throughput: one word per cycle while neither side stalls, set by the single-word front and back stages
// the four-entry queue and the result register let either side stall on its own
// reset (arst_n low, asynchronous) clears phase, counters, checksum and queue; hunt restarts
`timescale 1ns / 1ps

module snp_packet_deframer #(
	parameter int MAX_BATCH_WORDS = sdf_pkg::MAX_BATCH_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_buffer,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [2:0]  status,
	output logic [7:0]  packet_type,
	output logic [7:0]  reg_address,
	output logic [3:0]  word_index,
	output logic [31:0] data_word,
	output logic        last,
	output logic        out_valid,
	input  logic        out_stall
);
	import sdf_pkg::*;

	cmd_t        push_cmd, pop_cmd;
	queue_stat_t q_stat;
	logic        push, pop;

	sdf_front #(
		.MAX_BATCH_WORDS(MAX_BATCH_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.end_of_buffer(end_of_buffer),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.q_stat       (q_stat),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	sdf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.q_stat  (q_stat)
	);

	sdf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (pop_cmd),
		.q_stat     (q_stat),
		.pop        (pop),
		.status     (status),
		.packet_type(packet_type),
		.reg_address(reg_address),
		.word_index (word_index),
		.data_word  (data_word),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue flagged full and empty together");

	a_word_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (packet_type[7] && status == ST_OK))
		else $error("data word emitted for packet without data");

	a_status_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (data_word == 32'd0))
		else $error("status result carries data");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !push) |=> !pop || !q_stat.empty)
		else $error("pop from empty queue");

endmodule

// ===== src/sdf_front.sv =====
// front end of the snp packet deframer: header hunt, phase tracking, byte counting
// classifies each accepted word into a command for the back end; uses sdf_pkg
`timescale 1ns / 1ps

module sdf_front #(
	parameter int MAX_BATCH_WORDS = sdf_pkg::MAX_BATCH_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          rx_byte,
	input  logic                end_of_buffer,
	input  logic                in_valid,
	output logic                in_stall,
	input  sdf_pkg::queue_stat_t q_stat,
	output logic                push,
	output sdf_pkg::cmd_t       push_cmd
);
	import sdf_pkg::*;

	localparam logic [3:0] MAX_BL = 4'(MAX_BATCH_WORDS);

	phase_t      phase_q, phase_n;
	logic [15:0] prior_q, prior_n;
	logic [2:0]  count_q, count_n;
	logic [5:0]  left_q, left_n;
	logic [3:0]  batch_len;
	logic [5:0]  data_len;
	kind_t       kind;
	logic        hdr_hit;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;
	assign hdr_hit  = (rx_byte == CH_P) && (prior_q == {CH_S, CH_N});

	always_comb begin
		batch_len = (rx_byte[5:2] > MAX_BL) ? MAX_BL : rx_byte[5:2];
		if (!rx_byte[7]) begin
			data_len = 6'd0;
		end else if (rx_byte[6]) begin
			data_len = {batch_len, 2'b00};
		end else begin
			data_len = 6'd4;
		end
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		prior_n = prior_q;
		left_n  = left_q;
		count_n = (count_q == MIN_BUFFER_BYTES) ? count_q : count_q + 3'd1;
		case (phase_q)
			PH_HUNT: begin
				prior_n = {prior_q[7:0], rx_byte};
				if (hdr_hit) begin
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				left_n  = data_len;
				phase_n = PH_ADDR;
			end
			PH_ADDR: begin
				phase_n = (left_q != 6'd0) ? PH_DATA : PH_CKHI;
			end
			PH_DATA: begin
				left_n = (left_q != 6'd0) ? left_q - 6'd1 : 6'd0;
				if (left_n == 6'd0) begin
					phase_n = PH_CKHI;
				end
			end
			PH_CKHI: begin
				phase_n = PH_CKLO;
			end
			PH_CKLO: begin
				phase_n = PH_DONE;
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		case (phase_q)
			PH_HUNT: kind = hdr_hit ? K_HDR : K_IGNORE;
			PH_TYPE: kind = K_TYPE;
			PH_ADDR: kind = K_ADDR;
			PH_DATA: kind = K_DATA;
			PH_CKHI: kind = K_CKHI;
			PH_CKLO: kind = K_CKLO;
			default: kind = K_IGNORE;
		endcase
		push_cmd.kind     = kind;
		push_cmd.data     = rx_byte;
		push_cmd.eob      = end_of_buffer;
		push_cmd.eob_emit = end_of_buffer && (phase_n != PH_DONE);
		if (count_n < MIN_BUFFER_BYTES) begin
			push_cmd.eob_status = ST_SHORT;
		end else if (phase_n == PH_HUNT) begin
			push_cmd.eob_status = ST_NO_HEADER;
		end else begin
			push_cmd.eob_status = ST_TRUNCATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			prior_q <= '0;
			count_q <= '0;
			left_q  <= '0;
		end else if (push) begin
			if (end_of_buffer) begin
				phase_q <= PH_HUNT;
				prior_q <= '0;
				count_q <= '0;
				left_q  <= '0;
			end else begin
				phase_q <= phase_n;
				prior_q <= prior_n;
				count_q <= count_n;
				left_q  <= left_n;
			end
		end
	end

endmodule

// ===== src/sdf_queue.sv =====
// short command queue between front and back of the snp packet deframer
// circular buffer of classified words; uses sdf_pkg
`timescale 1ns / 1ps

module sdf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sdf_pkg::cmd_t        push_cmd,
	input  logic                 pop,
	output sdf_pkg::cmd_t        pop_cmd,
	output sdf_pkg::queue_stat_t q_stat
);
	import sdf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign q_stat.full  = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_cmd      = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/sdf_back.sv =====
// back end of the snp packet deframer: checksum, word assembly and result register
// carries out commands from the queue; uses sdf_pkg
`timescale 1ns / 1ps

module sdf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdf_pkg::cmd_t        cmd,
	input  sdf_pkg::queue_stat_t q_stat,
	output logic                 pop,
	output logic [2:0]           status,
	output logic [7:0]           packet_type,
	output logic [7:0]           reg_address,
	output logic [3:0]           word_index,
	output logic [31:0]          data_word,
	output logic                 last,
	output logic                 out_valid,
	input  logic                 out_stall
);
	import sdf_pkg::*;

	logic [7:0]  type_q, type_n;
	logic [7:0]  addr_q, addr_n;
	logic [23:0] asm_q, asm_n;
	logic [1:0]  biw_q, biw_n;
	logic [3:0]  wcnt_q, wcnt_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  ckhi_q, ckhi_n;
	logic [15:0] sum_add;

	logic        emit;
	status_t     res_status;
	logic [3:0]  res_index;
	logic [31:0] res_word;
	logic        res_last;

	logic        can_take;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  type_out_q, addr_out_q;
	logic [3:0]  index_q;
	logic [31:0] word_q;
	logic        last_q;

	assign can_take = !out_valid_q || !out_stall;
	assign pop      = can_take && !q_stat.empty;
	assign sum_add  = sum_q + {8'h00, cmd.data};

	always_comb begin
		type_n     = type_q;
		addr_n     = addr_q;
		asm_n      = asm_q;
		biw_n      = biw_q;
		wcnt_n     = wcnt_q;
		sum_n      = sum_q;
		ckhi_n     = ckhi_q;
		emit       = 1'b0;
		res_status = ST_OK;
		res_index  = wcnt_q;
		res_word   = '0;
		res_last   = 1'b0;
		case (cmd.kind)
			K_HDR: begin
				sum_n = HDR_SUM;
			end
			K_TYPE: begin
				type_n = cmd.data;
				sum_n  = sum_add;
			end
			K_ADDR: begin
				addr_n = cmd.data;
				sum_n  = sum_add;
			end
			K_DATA: begin
				sum_n = sum_add;
				if (biw_q == 2'd3) begin
					emit     = 1'b1;
					res_word = {asm_q, cmd.data};
					wcnt_n   = wcnt_q + 4'd1;
					biw_n    = 2'd0;
					asm_n    = '0;
				end else begin
					asm_n = {asm_q[15:0], cmd.data};
					biw_n = biw_q + 2'd1;
				end
			end
			K_CKHI: begin
				ckhi_n = cmd.data;
			end
			K_CKLO: begin
				emit       = 1'b1;
				res_last   = 1'b1;
				res_status = ({ckhi_q, cmd.data} == sum_q) ? ST_OK : ST_MISMATCH;
			end
			default: begin
			end
		endcase
		// end-of-buffer status overrides a word completed on the same byte
		if (cmd.eob_emit) begin
			emit       = 1'b1;
			res_last   = 1'b1;
			res_status = cmd.eob_status;
			res_index  = wcnt_n;
			res_word   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= '0;
			addr_q <= '0;
			asm_q  <= '0;
			biw_q  <= '0;
			wcnt_q <= '0;
			sum_q  <= '0;
			ckhi_q <= '0;
		end else if (pop) begin
			if (cmd.eob) begin
				type_q <= '0;
				addr_q <= '0;
				asm_q  <= '0;
				biw_q  <= '0;
				wcnt_q <= '0;
				sum_q  <= '0;
				ckhi_q <= '0;
			end else begin
				type_q <= type_n;
				addr_q <= addr_n;
				asm_q  <= asm_n;
				biw_q  <= biw_n;
				wcnt_q <= wcnt_n;
				sum_q  <= sum_n;
				ckhi_q <= ckhi_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_take) begin
			out_valid_q <= pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			status_q   <= res_status;
			type_out_q <= type_n;
			addr_out_q <= addr_n;
			index_q    <= res_index;
			word_q     <= res_word;
			last_q     <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign packet_type = type_out_q;
	assign reg_address = addr_out_q;
	assign word_index  = index_q;
	assign data_word   = word_q;
	assign last        = last_q;

endmodule

// ===== tb/sv/tb_snp_packet_deframer.sv =====
// testbench for the snp packet deframer: receive buffers of bytes, checked against a built-in predictor
// depends on sdf_pkg and snp_packet_deframer from src
`timescale 1ns / 1ps

module tb_snp_packet_deframer;
	import sdf_pkg::*;

	localparam int LIMIT_CYCLES   = 400000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct packed {
		status_t     st;
		logic [7:0]  ptype;
		logic [7:0]  addr;
		logic [3:0]  idx;
		logic [31:0] word;
		logic        fin;
	} deframe_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  status;
	logic [7:0]  packet_type;
	logic [7:0]  reg_address;
	logic [3:0]  word_index;
	logic [31:0] data_word;
	logic        last;
	logic        out_valid;
	logic        out_stall = 1'b0;

	// predictor state
	phase_t      pr_phase;
	logic [15:0] pr_prior;
	logic [2:0]  pr_count;
	logic [7:0]  pr_type;
	logic [7:0]  pr_addr;
	logic [5:0]  pr_left;
	logic [23:0] pr_assembly;
	logic [1:0]  pr_byte_in_word;
	logic [3:0]  pr_words;
	logic [15:0] pr_sum;
	logic [7:0]  pr_ck_high;

	deframe_result_t expected_results[$];
	logic [7:0]      pending_bytes[$];

	int errors = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_req = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;

	snp_packet_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.end_of_buffer (end_of_buffer),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.status        (status),
		.packet_type   (packet_type),
		.reg_address   (reg_address),
		.word_index    (word_index),
		.data_word     (data_word),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic clear_predictor();
		pr_phase        = PH_HUNT;
		pr_prior        = 16'h0000;
		pr_count        = 3'd0;
		pr_type         = 8'h00;
		pr_addr         = 8'h00;
		pr_left         = 6'd0;
		pr_assembly     = 24'h000000;
		pr_byte_in_word = 2'd0;
		pr_words        = 4'd0;
		pr_sum          = 16'h0000;
		pr_ck_high      = 8'h00;
	endtask

	// advance the predictor by one accepted word, queue the result it causes
	task automatic deframe_byte(input logic [7:0] b, input logic eob);
		deframe_result_t r;
		bit              have;
		logic [3:0]      batch;
		logic [6:0]      len;
		have = 0;
		r = '0;
		if (pr_count < MIN_BUFFER_BYTES)
			pr_count = pr_count + 3'd1;
		case (pr_phase)
			PH_HUNT: begin
				if (b == CH_P && pr_prior == {CH_S, CH_N}) begin
					pr_phase = PH_TYPE;
					pr_sum   = HDR_SUM;
				end
				pr_prior = {pr_prior[7:0], b};
			end
			PH_TYPE: begin
				pr_type = b;
				pr_sum  = pr_sum + {8'h00, b};
				len     = 7'd0;
				if (b[7]) begin
					if (b[6]) begin
						batch = b[5:2];
						if (batch > 4'(MAX_BATCH_WORDS_DEF))
							batch = 4'(MAX_BATCH_WORDS_DEF);
						len = 7'd4 * {3'd0, batch};
					end else begin
						len = 7'd4;
					end
				end
				pr_left  = len[5:0];
				pr_phase = PH_ADDR;
			end
			PH_ADDR: begin
				pr_addr  = b;
				pr_sum   = pr_sum + {8'h00, b};
				pr_phase = (pr_left != 6'd0) ? PH_DATA : PH_CKHI;
			end
			PH_DATA: begin
				pr_sum = pr_sum + {8'h00, b};
				if (pr_byte_in_word == 2'd3) begin
					r    = '{ST_OK, pr_type, pr_addr, pr_words, {pr_assembly, b}, 1'b0};
					have = 1;
					pr_words        = pr_words + 4'd1;
					pr_byte_in_word = 2'd0;
					pr_assembly     = 24'h000000;
				end else begin
					pr_assembly     = {pr_assembly[15:0], b};
					pr_byte_in_word = pr_byte_in_word + 2'd1;
				end
				if (pr_left != 6'd0)
					pr_left = pr_left - 6'd1;
				if (pr_left == 6'd0)
					pr_phase = PH_CKHI;
			end
			PH_CKHI: begin
				pr_ck_high = b;
				pr_phase   = PH_CKLO;
			end
			PH_CKLO: begin
				r = '{({pr_ck_high, b} == pr_sum) ? ST_OK : ST_MISMATCH,
					pr_type, pr_addr, pr_words, 32'h0, 1'b1};
				have     = 1;
				pr_phase = PH_DONE;
			end
			default: begin
			end
		endcase
		if (eob) begin
			// the end-of-buffer status replaces any word result of the same byte
			if (pr_phase != PH_DONE) begin
				r.st = (pr_count < MIN_BUFFER_BYTES) ? ST_SHORT :
					(pr_phase == PH_HUNT) ? ST_NO_HEADER : ST_TRUNCATED;
				r.ptype = pr_type;
				r.addr  = pr_addr;
				r.idx   = pr_words;
				r.word  = 32'h0;
				r.fin   = 1'b1;
				have    = 1;
			end
			clear_predictor();
		end
		if (have)
			expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		deframe_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", {29'd0, status}, 32'h0);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.st)
					report_mismatch("status", {29'd0, status}, {29'd0, e.st});
				if (packet_type !== e.ptype)
					report_mismatch("packet_type", {24'd0, packet_type}, {24'd0, e.ptype});
				if (reg_address !== e.addr)
					report_mismatch("reg_address", {24'd0, reg_address}, {24'd0, e.addr});
				if (word_index !== e.idx)
					report_mismatch("word_index", {28'd0, word_index}, {28'd0, e.idx});
				if (data_word !== e.word)
					report_mismatch("data_word", data_word, e.word);
				if (last !== e.fin)
					report_mismatch("last", {31'd0, last}, {31'd0, e.fin});
			end
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (holdoff_seen != holdoff_req) begin
			holdoff_seen = holdoff_req;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eob);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		rx_byte       <= b;
		end_of_buffer <= eob;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_byte(b, eob);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		int n;
		n = pending_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(pending_bytes[i], i == n - 1);
		pending_bytes.delete();
	endtask

	task automatic add_packet(input logic [7:0] ptype, input logic [7:0] addr, input bit bad_ck);
		logic [15:0] sum;
		logic [7:0]  d;
		int          nbytes;
		sum = HDR_SUM;
		pending_bytes.push_back(CH_S);
		pending_bytes.push_back(CH_N);
		pending_bytes.push_back(CH_P);
		pending_bytes.push_back(ptype);
		pending_bytes.push_back(addr);
		sum = sum + {8'h00, ptype} + {8'h00, addr};
		nbytes = ptype[7] ? (ptype[6] ? 4 * int'(ptype[5:2]) : 4) : 0;
		for (int i = 0; i < nbytes; i++) begin
			d = 8'($urandom);
			pending_bytes.push_back(d);
			sum = sum + {8'h00, d};
		end
		if (bad_ck)
			sum = sum + 16'($urandom_range(1, 65535));
		pending_bytes.push_back(sum[15:8]);
		pending_bytes.push_back(sum[7:0]);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic rand_buffer();
		logic [7:0] ptype;
		int         cut;
		int         n;
		if ($urandom_range(0, 9) < 3) begin
			n = $urandom_range(1, 3);
			repeat (n) pending_bytes.push_back(8'($urandom));
		end
		if ($urandom_range(0, 99) < 75) begin
			ptype = 8'($urandom);
			if ($urandom_range(0, 9) < 8)
				ptype[5:2] = 4'($urandom_range(0, 3));
			if ($urandom_range(0, 9) < 6)
				ptype[7] = 1'b1;
			add_packet(ptype, 8'($urandom), $urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, pending_bytes.size() - 1);
				repeat (cut) void'(pending_bytes.pop_back());
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) pending_bytes.push_back(8'($urandom));
			end
		end else begin
			// noise, sometimes with a broken header in it
			n = $urandom_range(1, 12);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					pending_bytes.push_back(CH_S);
					pending_bytes.push_back(CH_N);
				end else begin
					pending_bytes.push_back(8'($urandom));
				end
			end
		end
		send_buffer();
	endtask

	task automatic test_directed();
		pending_bytes = '{CH_S, CH_N};
		send_buffer();
		pending_bytes = '{8'h00, 8'hFF, CH_S, CH_N, 8'h41, CH_P, 8'h55};
		send_buffer();
		add_packet(8'h00, 8'hFF, 0);
		send_buffer();
		add_packet(8'h80, 8'h00, 1);
		send_buffer();
		// truncated on the byte that completes a data word
		add_packet(8'hC4, 8'h12, 0);
		repeat (2) void'(pending_bytes.pop_back());
		send_buffer();
		// batch with zero length
		add_packet(8'hC0, 8'hA5, 0);
		send_buffer();
		wait_drain();
	endtask

	task automatic test_random(input int sender_pct, input int receiver_pct, input int count);
		int stop_at;
		send_idle_pct = sender_pct;
		stall_pct     = receiver_pct;
		stop_at       = bytes_sent + count;
		while (bytes_sent < stop_at)
			rand_buffer();
		wait_drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		holdoff_req++;
		repeat (2) begin
			add_packet(8'hFC, 8'($urandom), 0);
			send_buffer();
		end
		wait_drain();
	endtask

	initial begin
		clear_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 0, 210);
		test_random(67, 0, 210);
		test_random(0, 67, 210);
		test_random(24, 24, 210);
		test_backpressure();
		wait_drain();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sdf_pkg.sv
src/sdf_front.sv
src/sdf_queue.sv
src/sdf_back.sv
src/snp_packet_deframer.sv
tb/sv/tb_snp_packet_deframer.sv
